### hw/rtl/nfci_pkg.sv
// ----------------------------------------------------------------------------
// nfci_pkg
// Types, command codes and the query table of the NOR flash command interface.
// ----------------------------------------------------------------------------
`default_nettype none

package nfci_pkg;

  // array geometry
  localparam int unsigned ADDR_W           = 20;
  localparam int unsigned SECTOR_HALFWORDS = 2048;
  localparam int unsigned BLOCK_HALFWORDS  = 32768;
  localparam int unsigned CFI_ENTRIES      = 53;
  localparam int unsigned CFI_TABLE_LEN    = 53;
  localparam int unsigned CFI_LIMIT        =
      (CFI_ENTRIES < CFI_TABLE_LEN) ? CFI_ENTRIES : CFI_TABLE_LEN;
  localparam int unsigned CFI_IDX_W        = 6;

  localparam logic [ADDR_W-1:0] SECTOR_MASK = ADDR_W'(SECTOR_HALFWORDS - 1);
  localparam logic [ADDR_W-1:0] BLOCK_MASK  = ADDR_W'(BLOCK_HALFWORDS - 1);
  localparam logic [ADDR_W-1:0] CMD_ADDR1   = ADDR_W'(32'h5555);
  localparam logic [ADDR_W-1:0] CMD_ADDR2   = ADDR_W'(32'h2aaa);

  // command bytes
  localparam logic [7:0] CMD_UNLOCK1  = 8'haa;
  localparam logic [7:0] CMD_UNLOCK2  = 8'h55;
  localparam logic [7:0] CMD_PROGRAM  = 8'ha0;
  localparam logic [7:0] CMD_ERASE    = 8'h80;
  localparam logic [7:0] CMD_ID       = 8'h90;
  localparam logic [7:0] CMD_CFI      = 8'h98;
  localparam logic [7:0] CMD_EXIT     = 8'hf0;
  localparam logic [7:0] CMD_CHIP_ER  = 8'h10;
  localparam logic [7:0] CMD_SECT_ER  = 8'h30;
  localparam logic [7:0] CMD_BLOCK_ER = 8'h50;

  // configuration register indexes
  localparam logic REG_VENDOR_ID = 1'b0;
  localparam logic REG_DEVICE_ID = 1'b1;

  // access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [3:0] {
    MODE_NORMAL  = 4'd0,
    MODE_UNLOCK1 = 4'd1,
    MODE_UNLOCK2 = 4'd2,
    MODE_ERASE1  = 4'd3,
    MODE_ERASE2  = 4'd4,
    MODE_ERASE3  = 4'd5,
    MODE_IDX1    = 4'd6,
    MODE_IDX2    = 4'd7,
    MODE_CFIX1   = 4'd8,
    MODE_CFIX2   = 4'd9,
    MODE_ID      = 4'd10,
    MODE_CFI     = 4'd11,
    MODE_PROG    = 4'd12
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PROG,
    ST_ERASE
  } seq_state_e;

  // command mode after a write cycle
  function automatic mode_e next_mode(mode_e mode, logic at1, logic at2,
                                      logic [7:0] cmd);
    mode_e nxt;
    nxt = mode;
    case (mode)
      MODE_UNLOCK1: nxt = (at2 && cmd == CMD_UNLOCK2) ? MODE_UNLOCK2 : MODE_NORMAL;
      MODE_UNLOCK2: begin
        nxt = MODE_NORMAL;
        if (at1) begin
          if (cmd == CMD_PROGRAM)  nxt = MODE_PROG;
          else if (cmd == CMD_ERASE) nxt = MODE_ERASE1;
          else if (cmd == CMD_ID)    nxt = MODE_ID;
          else if (cmd == CMD_CFI)   nxt = MODE_CFI;
        end
      end
      MODE_ERASE1: nxt = (at1 && cmd == CMD_UNLOCK1) ? MODE_ERASE2 : MODE_NORMAL;
      MODE_ERASE2: nxt = (at2 && cmd == CMD_UNLOCK2) ? MODE_ERASE3 : MODE_NORMAL;
      MODE_ERASE3: nxt = MODE_NORMAL;
      MODE_IDX1:   nxt = (at2 && cmd == CMD_UNLOCK2) ? MODE_IDX2 : MODE_ID;
      MODE_IDX2:   nxt = (at1 && cmd == CMD_EXIT) ? MODE_NORMAL : MODE_ID;
      MODE_CFIX1:  nxt = (at2 && cmd == CMD_UNLOCK2) ? MODE_CFIX2 : MODE_CFI;
      MODE_CFIX2:  nxt = (at1 && cmd == CMD_EXIT) ? MODE_NORMAL : MODE_CFI;
      MODE_ID: begin
        if (at1 && cmd == CMD_UNLOCK1) nxt = MODE_IDX1;
        else if (cmd == CMD_EXIT)      nxt = MODE_NORMAL;
      end
      MODE_CFI: begin
        if (at1 && cmd == CMD_UNLOCK1) nxt = MODE_CFIX1;
        else if (cmd == CMD_EXIT)      nxt = MODE_NORMAL;
      end
      MODE_PROG:   nxt = MODE_NORMAL;
      default:     nxt = (at1 && cmd == CMD_UNLOCK1) ? MODE_UNLOCK1 : MODE_NORMAL;
    endcase
    return nxt;
  endfunction

  // common flash interface query table
  function automatic logic [15:0] cfi_entry(logic [CFI_IDX_W-1:0] idx);
    logic [15:0] val;
    val = 16'h0000;
    case (idx)
      6'd16:   val = 16'h0051;
      6'd17:   val = 16'h0052;
      6'd18:   val = 16'h0059;
      6'd19:   val = 16'h0001;
      6'd20:   val = 16'h0007;
      6'd27:   val = 16'h0027;
      6'd28:   val = 16'h0036;
      6'd31:   val = 16'h0004;
      6'd33:   val = 16'h0004;
      6'd34:   val = 16'h0006;
      6'd35:   val = 16'h0001;
      6'd37:   val = 16'h0001;
      6'd38:   val = 16'h0001;
      6'd39:   val = 16'h0015;
      6'd40:   val = 16'h0001;
      6'd44:   val = 16'h0002;
      6'd45:   val = 16'h00ff;
      6'd46:   val = 16'h0001;
      6'd47:   val = 16'h0010;
      6'd49:   val = 16'h003f;
      6'd52:   val = 16'h0001;
      default: val = 16'h0000;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/nor_flash_command_interface.sv
// ----------------------------------------------------------------------------
// nor_flash_command_interface
// Halfword NOR flash model with unlock command sequencer and on-chip array.
// ----------------------------------------------------------------------------
// Usage: each item on the slave stream is one bus access (tuser = 0 read,
// 1 write). Each access gives exactly one result item on the master stream:
// the read data (zero for writes) and the command mode after the access.
// The vendor and device codes are set through the cfg write channel, which
// is always ready; write it only while no access is in flight.
// Path from accept to result valid:
//   ID or CFI read, command write ........ result registered on accept
//   array read, word program ............. read port, then result and write-back
//   sector / block / chip erase .......... sweep of the sector, block or whole array
// Erases write one halfword per cycle through the single array write port.
// The next item can be taken the cycle after the result is taken.
// One item at a time: s_axis_tready is low while an access is at work and
// while a result waits on the master side, so a stalled receiver holds the
// block. After reset the array is filled with ones, one halfword a cycle,
// before the first item is taken; config writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module nor_flash_command_interface (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // access items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // address[19:0], write_data[35:20], zero pad
  input  wire logic        s_axis_tuser,   // kind[0]
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,   // read_data[15:0], mode[19:16], zero pad
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned AW    = nfci_pkg::ADDR_W;
  localparam int unsigned DEPTH = 1 << AW;

  // input fields
  logic [AW-1:0] in_addr;
  logic [15:0]   in_data;
  logic [7:0]    in_cmd;
  logic          in_kind;
  logic          in_fire;
  logic          at1;
  logic          at2;

  assign in_addr = s_axis_tdata[AW-1:0];
  assign in_data = s_axis_tdata[AW+15:AW];
  assign in_cmd  = in_data[7:0];
  assign in_kind = s_axis_tuser;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign at1     = (in_addr == nfci_pkg::CMD_ADDR1);
  assign at2     = (in_addr == nfci_pkg::CMD_ADDR2);

  // state
  nfci_pkg::seq_state_e st_q, st_d;
  nfci_pkg::mode_e      mode_q, mode_d;
  logic [15:0]          vendor_q, device_q;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic [AW-1:0]        last_q, last_d;
  logic [15:0]          wdata_q, wdata_d;
  logic                 out_valid_q, out_valid_d;
  logic [15:0]          out_data_q, out_data_d;

  // array ports
  logic [15:0]   mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic          mem_re;
  logic [15:0]   rdata_q;

  // decoded access
  logic          is_erase_cmd;
  logic          sweep_done;

  assign is_erase_cmd = (in_cmd == nfci_pkg::CMD_CHIP_ER) ||
                        (in_cmd == nfci_pkg::CMD_SECT_ER) ||
                        (in_cmd == nfci_pkg::CMD_BLOCK_ER);
  assign sweep_done   = (ptr_q == last_q);

  // input ready only when idle with no result waiting
  assign s_axis_tready = (st_q == nfci_pkg::ST_IDLE) && !out_valid_q;

  // sequencer next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      nfci_pkg::ST_CLEAR: if (sweep_done) st_d = nfci_pkg::ST_IDLE;
      nfci_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_kind == nfci_pkg::KIND_READ) begin
            if (mode_q != nfci_pkg::MODE_ID && mode_q != nfci_pkg::MODE_CFI) begin
              st_d = nfci_pkg::ST_READ;
            end
          end else if (mode_q == nfci_pkg::MODE_PROG) begin
            st_d = nfci_pkg::ST_PROG;
          end else if (mode_q == nfci_pkg::MODE_ERASE3 && is_erase_cmd) begin
            st_d = nfci_pkg::ST_ERASE;
          end
        end
      end
      nfci_pkg::ST_READ:  st_d = nfci_pkg::ST_IDLE;
      nfci_pkg::ST_PROG:  st_d = nfci_pkg::ST_IDLE;
      nfci_pkg::ST_ERASE: if (sweep_done) st_d = nfci_pkg::ST_IDLE;
      default:            st_d = nfci_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath control
  always_comb begin
    mode_d        = mode_q;
    ptr_d         = ptr_q;
    last_d        = last_q;
    wdata_d       = wdata_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_data_d    = out_data_q;
    mem_we        = 1'b0;
    mem_wa        = ptr_q;
    mem_wd        = 16'hffff;
    mem_re        = 1'b0;
    case (st_q)
      nfci_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + AW'(1);
      end
      nfci_pkg::ST_IDLE: begin
        if (in_fire) begin
          ptr_d   = in_addr;
          wdata_d = in_data;
          if (in_kind == nfci_pkg::KIND_READ) begin
            if (mode_q == nfci_pkg::MODE_ID) begin
              out_valid_d = 1'b1;
              out_data_d  = in_addr[0] ? device_q : vendor_q;
            end else if (mode_q == nfci_pkg::MODE_CFI) begin
              out_valid_d = 1'b1;
              out_data_d  = (in_addr < AW'(nfci_pkg::CFI_LIMIT)) ?
                  nfci_pkg::cfi_entry(in_addr[nfci_pkg::CFI_IDX_W-1:0]) : 16'h0000;
            end else begin
              // unfinished sequence falls back to array read
              mode_d = nfci_pkg::MODE_NORMAL;
              mem_re = 1'b1;
            end
          end else begin
            mode_d = nfci_pkg::next_mode(mode_q, at1, at2, in_cmd);
            if (mode_q == nfci_pkg::MODE_PROG) begin
              mem_re = 1'b1;
            end else if (mode_q == nfci_pkg::MODE_ERASE3 && is_erase_cmd) begin
              if (in_cmd == nfci_pkg::CMD_SECT_ER) begin
                ptr_d  = in_addr & ~nfci_pkg::SECTOR_MASK;
                last_d = in_addr | nfci_pkg::SECTOR_MASK;
              end else if (in_cmd == nfci_pkg::CMD_BLOCK_ER) begin
                ptr_d  = in_addr & ~nfci_pkg::BLOCK_MASK;
                last_d = in_addr | nfci_pkg::BLOCK_MASK;
              end else begin
                ptr_d  = '0;
                last_d = '1;
              end
            end else begin
              out_valid_d = 1'b1;
              out_data_d  = 16'h0000;
            end
          end
        end
      end
      nfci_pkg::ST_READ: begin
        out_valid_d = 1'b1;
        out_data_d  = rdata_q;
      end
      nfci_pkg::ST_PROG: begin
        // program can only clear bits
        mem_we      = 1'b1;
        mem_wd      = rdata_q & wdata_q;
        out_valid_d = 1'b1;
        out_data_d  = 16'h0000;
      end
      nfci_pkg::ST_ERASE: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + AW'(1);
        if (sweep_done) begin
          out_valid_d = 1'b1;
          out_data_d  = 16'h0000;
        end
      end
      default: ;
    endcase
  end

  // control and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= nfci_pkg::ST_CLEAR;
      mode_q      <= nfci_pkg::MODE_NORMAL;
      ptr_q       <= '0;
      last_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      mode_q      <= mode_d;
      ptr_q       <= ptr_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wdata_q    <= wdata_d;
    out_data_q <= out_data_d;
  end

  // id registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vendor_q <= 16'd191;
      device_q <= 16'd10114;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        nfci_pkg::REG_VENDOR_ID: vendor_q <= cfg_data_i;
        nfci_pkg::REG_DEVICE_ID: device_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // flash array, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[in_addr];
    end
  end

  // result stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, mode_q, out_data_q};

endmodule

`default_nettype wire
